### rtl/core/fcca_pkg.sv
// ----------------------------------------------------------------------------
// FAT cluster chain allocator package
// Sizes, function and status codes, and the link table access type.
// ----------------------------------------------------------------------------
package fcca_pkg;

    localparam int NUM_CLUSTERS = 1024;
    localparam int CLUSTER_W    = 10;
    localparam int LEN_W        = 11;

    // Cluster constants
    localparam logic [CLUSTER_W-1:0] CL_FIRST = CLUSTER_W'(2);
    localparam logic [CLUSTER_W-1:0] CL_LAST  = CLUSTER_W'(NUM_CLUSTERS - 1);
    localparam logic [LEN_W-1:0]     CL_NUM   = LEN_W'(NUM_CLUSTERS);
    localparam logic [LEN_W-1:0]     FREE_MAX = LEN_W'(NUM_CLUSTERS - 2);

    // Link table entry codes
    localparam logic [CLUSTER_W-1:0] LINK_FREE = CLUSTER_W'(0);
    localparam logic [CLUSTER_W-1:0] LINK_END  = CLUSTER_W'(1);

    // Function codes
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_LENGTH = 2'd2;
    localparam logic [1:0] FUNC_FIND   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ZERO    = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;

    // One access to the link table: one write and one read per cycle
    typedef struct packed {
        logic                 we;
        logic [CLUSTER_W-1:0] waddr;
        logic [CLUSTER_W-1:0] wdata;
        logic [CLUSTER_W-1:0] raddr;
    } t_tbl_req;

endpackage

### rtl/core/fcca_ifs.sv
// ----------------------------------------------------------------------------
// FAT cluster chain allocator channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fcca_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic [fcca_pkg::CLUSTER_W-1:0]  cluster;
    logic [fcca_pkg::LEN_W-1:0]      count;

    modport source (output valid, func, cluster, count, input ready);
    modport sink   (input valid, func, cluster, count, output ready);
endinterface

interface fcca_res_if;
    logic                            valid;
    logic                            ready;
    logic [fcca_pkg::CLUSTER_W-1:0]  head_cluster;
    logic [fcca_pkg::LEN_W-1:0]      chain_length;
    logic [1:0]                      status;

    modport source (output valid, head_cluster, chain_length, status, input ready);
    modport sink   (input valid, head_cluster, chain_length, status, output ready);
endinterface

### rtl/core/fcca_table.sv
// ----------------------------------------------------------------------------
// FAT link table
// Synchronous link memory, one write and one registered read per cycle,
// write data forwarded to a read of the same entry, cleared after reset.
// ----------------------------------------------------------------------------
module fcca_table (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fcca_pkg::t_tbl_req                   i_req,
    output logic [fcca_pkg::CLUSTER_W-1:0]       o_rdata,
    output logic                                 o_busy
);

    logic [fcca_pkg::CLUSTER_W-1:0] mem [fcca_pkg::NUM_CLUSTERS];
    logic [fcca_pkg::CLUSTER_W-1:0] r_rdata;
    logic [fcca_pkg::CLUSTER_W-1:0] r_clr_addr;
    logic                           r_clr_busy;

    // Clearing pass: one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == fcca_pkg::CL_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= fcca_pkg::LINK_FREE;
        end else if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Forward the write so a read of the same entry sees the new value
    always_ff @(posedge i_clk) begin
        if (i_req.we && !r_clr_busy && (i_req.waddr == i_req.raddr)) begin
            r_rdata <= i_req.wdata;
        end else begin
            r_rdata <= mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

### rtl/core/fat_cluster_chain_allocator.sv
// Allocate scans the table one entry per cycle; free and chain length follow one link per cycle;
// find head rescans the table from the first cluster for each predecessor step, at most
// NUM_CLUSTERS steps, then walks the chain from the head. One item is in work at a time.
// Reset: synchronous, active low; the link table is cleared after reset, and no item is
// accepted until the clearing pass is done.
// ----------------------------------------------------------------------------
// FAT cluster chain allocator
// First-fit chain allocation, chain free, chain length and chain head search
// over a link table held in one synchronous memory.
// ----------------------------------------------------------------------------
module fat_cluster_chain_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcca_req_if.sink    i_req,
    fcca_res_if.source  o_res
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ALLOC     = 3'd1;
    localparam logic [2:0] S_ALLOC_END = 3'd2;
    localparam logic [2:0] S_WALK      = 3'd3;
    localparam logic [2:0] S_FIND_CHK  = 3'd4;
    localparam logic [2:0] S_FIND_SCAN = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    localparam int CW = fcca_pkg::CLUSTER_W;
    localparam int LW = fcca_pkg::LEN_W;

    fcca_pkg::t_tbl_req tbl_req;
    logic [CW-1:0]      rd;
    logic               tbl_busy;
    logic               in_ready;

    logic [2:0]    r_state,    n_state;
    logic [1:0]    r_func,     n_func;
    logic [CW-1:0] r_cur,      n_cur;
    logic [LW-1:0] r_issue,    n_issue;
    logic          r_rd_vld,   n_rd_vld;
    logic [CW-1:0] r_rd_addr,  n_rd_addr;
    logic [LW-1:0] r_left,     n_left;
    logic [CW-1:0] r_prev,     n_prev;
    logic [CW-1:0] r_head,     n_head;
    logic [LW-1:0] r_len,      n_len;
    logic [1:0]    r_status,   n_status;
    logic [LW-1:0] r_free_cnt, n_free_cnt;

    logic          r_o_valid,  n_o_valid;
    logic [CW-1:0] r_o_head,   n_o_head;
    logic [LW-1:0] r_o_len,    n_o_len;
    logic [1:0]    r_o_status, n_o_status;

    fcca_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rdata (rd),
        .o_busy  (tbl_busy)
    );

    assign in_ready = (r_state == S_IDLE) && !tbl_busy;

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_cur      = r_cur;
        n_issue    = r_issue;
        n_rd_vld   = r_rd_vld;
        n_rd_addr  = r_rd_addr;
        n_left     = r_left;
        n_prev     = r_prev;
        n_head     = r_head;
        n_len      = r_len;
        n_status   = r_status;
        n_free_cnt = r_free_cnt;
        n_o_valid  = r_o_valid && !o_res.ready;
        n_o_head   = r_o_head;
        n_o_len    = r_o_len;
        n_o_status = r_o_status;

        tbl_req.we    = 1'b0;
        tbl_req.waddr = r_prev;
        tbl_req.wdata = fcca_pkg::LINK_FREE;
        tbl_req.raddr = r_cur;

        case (r_state)
            S_IDLE: begin
                tbl_req.raddr = i_req.cluster;
                if (i_req.valid && in_ready) begin
                    n_func    = i_req.func;
                    n_cur     = i_req.cluster;
                    n_head    = '0;
                    n_len     = '0;
                    n_status  = fcca_pkg::STAT_OK;
                    n_prev    = '0;
                    n_left    = i_req.count;
                    n_issue   = LW'(fcca_pkg::CL_FIRST);
                    n_rd_vld  = 1'b0;
                    case (i_req.func)
                        fcca_pkg::FUNC_ALLOC: begin
                            if (i_req.count == '0) begin
                                n_status = fcca_pkg::STAT_ZERO;
                                n_state  = S_DONE;
                            end else if (i_req.count > r_free_cnt) begin
                                n_status = fcca_pkg::STAT_NOSPACE;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        fcca_pkg::FUNC_FREE:   n_state = S_WALK;
                        fcca_pkg::FUNC_LENGTH: n_state = S_WALK;
                        fcca_pkg::FUNC_FIND:   n_state = S_FIND_CHK;
                        default:               n_state = S_DONE;
                    endcase
                end
            end

            S_ALLOC: begin
                // Stream reads upward; link each free entry into the chain
                tbl_req.raddr = r_issue[CW-1:0];
                n_rd_vld      = r_issue < fcca_pkg::CL_NUM;
                n_rd_addr     = r_issue[CW-1:0];
                if (r_issue < fcca_pkg::CL_NUM) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_rd_vld) begin
                    if (rd == fcca_pkg::LINK_FREE) begin
                        tbl_req.we    = (r_prev != '0);
                        tbl_req.waddr = r_prev;
                        tbl_req.wdata = r_rd_addr;
                        if (r_prev == '0) begin
                            n_head = r_rd_addr;
                        end
                        n_prev     = r_rd_addr;
                        n_left     = r_left - 1'b1;
                        n_free_cnt = r_free_cnt - 1'b1;
                    end
                    if (((rd == fcca_pkg::LINK_FREE) && (r_left == LW'(1)))
                            || (r_rd_addr == fcca_pkg::CL_LAST)) begin
                        n_state = S_ALLOC_END;
                    end
                end
            end

            S_ALLOC_END: begin
                // Terminate the chain at its last cluster
                tbl_req.we    = (r_prev != '0);
                tbl_req.waddr = r_prev;
                tbl_req.wdata = fcca_pkg::LINK_END;
                n_state       = S_DONE;
            end

            S_WALK: begin
                // rd holds the link of r_cur
                if ((r_cur >= fcca_pkg::CL_FIRST) && ({1'b0, r_cur} < fcca_pkg::CL_NUM)
                        && (rd != fcca_pkg::LINK_FREE) && (r_len < fcca_pkg::CL_NUM)) begin
                    if (r_func == fcca_pkg::FUNC_FREE) begin
                        tbl_req.we    = 1'b1;
                        tbl_req.waddr = r_cur;
                        tbl_req.wdata = fcca_pkg::LINK_FREE;
                        if (r_free_cnt < fcca_pkg::FREE_MAX) begin
                            n_free_cnt = r_free_cnt + 1'b1;
                        end
                    end
                    n_len         = r_len + 1'b1;
                    n_cur         = rd;
                    tbl_req.raddr = rd;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_FIND_CHK: begin
                // Start the predecessor scan if the cluster holds a chain
                if ((r_cur >= fcca_pkg::CL_FIRST) && (rd != fcca_pkg::LINK_FREE)) begin
                    tbl_req.raddr = fcca_pkg::CL_FIRST;
                    n_issue       = LW'(fcca_pkg::CL_FIRST) + 1'b1;
                    n_rd_vld      = 1'b1;
                    n_rd_addr     = fcca_pkg::CL_FIRST;
                    n_len         = '0;
                    n_state       = S_FIND_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_FIND_SCAN: begin
                tbl_req.raddr = r_issue[CW-1:0];
                n_rd_vld      = r_issue < fcca_pkg::CL_NUM;
                n_rd_addr     = r_issue[CW-1:0];
                if (r_issue < fcca_pkg::CL_NUM) begin
                    n_issue = r_issue + 1'b1;
                end
                if (r_rd_vld && (rd == r_cur)) begin
                    // Predecessor found: step back, rescan from the first cluster unless the step limit is reached
                    n_cur = r_rd_addr;
                    n_len = r_len + 1'b1;
                    if ((r_len + 1'b1) == fcca_pkg::CL_NUM) begin
                        tbl_req.raddr = r_rd_addr;
                        n_head        = r_rd_addr;
                        n_len         = '0;
                        n_state       = S_WALK;
                    end else begin
                        tbl_req.raddr = fcca_pkg::CL_FIRST;
                        n_issue       = LW'(fcca_pkg::CL_FIRST) + 1'b1;
                        n_rd_vld      = 1'b1;
                        n_rd_addr     = fcca_pkg::CL_FIRST;
                    end
                end else if (r_rd_vld && (r_rd_addr == fcca_pkg::CL_LAST)) begin
                    // No predecessor: r_cur is the head, measure its chain
                    tbl_req.raddr = r_cur;
                    n_head        = r_cur;
                    n_len         = '0;
                    n_state       = S_WALK;
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!r_o_valid || o_res.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_head   = r_head;
                    n_o_len    = ((r_func == fcca_pkg::FUNC_LENGTH)
                                  || (r_func == fcca_pkg::FUNC_FIND)) ? r_len : '0;
                    n_o_status = r_status;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_free_cnt <= fcca_pkg::FREE_MAX;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= n_rd_vld;
            r_free_cnt <= n_free_cnt;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_cur      <= n_cur;
        r_issue    <= n_issue;
        r_rd_addr  <= n_rd_addr;
        r_left     <= n_left;
        r_prev     <= n_prev;
        r_head     <= n_head;
        r_len      <= n_len;
        r_status   <= n_status;
        r_o_head   <= n_o_head;
        r_o_len    <= n_o_len;
        r_o_status <= n_o_status;
    end

    assign i_req.ready        = in_ready;
    assign o_res.valid        = r_o_valid;
    assign o_res.head_cluster = r_o_head;
    assign o_res.chain_length = r_o_len;
    assign o_res.status       = r_o_status;

endmodule
